@@ design/ncl_pkg.sv @@
// ----------------------------------------------------------------------------
// ncl_pkg
// Shared constants, types and controller codes for the leader clustering block.
// ----------------------------------------------------------------------------
package ncl_pkg;

  localparam int MAX_CLUSTERS = 64;
  localparam int FRAC_BITS    = 16;

  localparam int FREQ_W      = FRAC_BITS + 1;
  localparam int WEIGHT_W    = 32;
  localparam int WSTORE_W    = 48;
  localparam int OUT_IDX_W   = 6;
  localparam int IDX_W       = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int CNT_W       = $clog2(MAX_CLUSTERS + 1);
  localparam int PROD_W      = FREQ_W + WEIGHT_W;
  localparam int ACC_W       = FREQ_W + WSTORE_W + 1;
  localparam int SUM_W       = WSTORE_W + 1;
  localparam int DIV_CNT_W   = $clog2(FREQ_W + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_READ,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_EV,
    S_DIV_INIT,
    S_DIV,
    S_JOIN,
    S_FINISH
  } ncl_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic read_best;
    logic mul_lo;
    logic mul_hi;
    logic mul_ev;
    logic div_init;
    logic div_step;
    logic write_join;
    logic open_new;
    logic drop;
    logic emit;
  } ncl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic match;
    logic full;
    logic div_done;
  } ncl_stat_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] cluster_index;
    logic                 opened_new;
    logic [FREQ_W-1:0]    cluster_centroid;
    logic                 dropped;
  } ncl_result_t;

endpackage

@@ design/ncl_if.sv @@
// ----------------------------------------------------------------------------
// ncl_if
// Valid/ready channels for events, results and the threshold register.
// ----------------------------------------------------------------------------
interface ncl_evt_if;
  logic                       valid;
  logic                       ready;
  logic [ncl_pkg::FREQ_W-1:0]   event_frequency;
  logic [ncl_pkg::WEIGHT_W-1:0] event_weight;
  logic                       start_new_set;

  modport source (output valid, event_frequency, event_weight, start_new_set, input ready);
  modport sink   (input valid, event_frequency, event_weight, start_new_set, output ready);
endinterface

interface ncl_res_if;
  logic                          valid;
  logic                          ready;
  logic [ncl_pkg::OUT_IDX_W-1:0] cluster_index;
  logic                          opened_new;
  logic [ncl_pkg::FREQ_W-1:0]    cluster_centroid;
  logic                          dropped;

  modport source (output valid, cluster_index, opened_new, cluster_centroid, dropped,
                  input ready);
  modport sink   (input valid, cluster_index, opened_new, cluster_centroid, dropped,
                  output ready);
endinterface

interface ncl_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ncl_pkg::FREQ_W-1:0] join_threshold;

  modport source (output valid, join_threshold, input ready);
  modport sink   (input valid, join_threshold, output ready);
endinterface

@@ design/ncl_datapath.sv @@
// ----------------------------------------------------------------------------
// ncl_datapath
// Cluster stores, nearest-centroid scan, weighted-mean multiply and divide.
// ----------------------------------------------------------------------------
module ncl_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  ncl_pkg::ncl_cmd_t             cmd,
  output ncl_pkg::ncl_stat_t            stat,
  input  logic [ncl_pkg::FREQ_W-1:0]    evt_frequency,
  input  logic [ncl_pkg::WEIGHT_W-1:0]  evt_weight,
  input  logic                          evt_start,
  input  logic                          cfg_valid,
  input  logic [ncl_pkg::FREQ_W-1:0]    cfg_threshold,
  output ncl_pkg::ncl_result_t          res_data
);
  import ncl_pkg::*;

  localparam logic [FREQ_W-1:0] FIX_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [FREQ_W-1:0]    thr;
  logic [FREQ_W-1:0]    thr_clamp;
  logic [CNT_W-1:0]     count;
  logic [FREQ_W-1:0]    freq_q;
  logic [WEIGHT_W-1:0]  weight_q;

  logic [FREQ_W-1:0]    cent_mem [MAX_CLUSTERS];
  logic [WSTORE_W-1:0]  wgt_mem  [MAX_CLUSTERS];
  logic [FREQ_W-1:0]    cent_rd;
  logic [WSTORE_W-1:0]  wgt_rd;
  logic                 mem_re;
  logic                 mem_we;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  logic [FREQ_W-1:0]    wr_cent;
  logic [WSTORE_W-1:0]  wr_wgt;

  logic [CNT_W-1:0]     scan_idx;
  logic                 scan_more;
  logic                 rd_valid;
  logic [IDX_W-1:0]     rd_idx;
  logic                 found;
  logic [IDX_W-1:0]     best_idx;
  logic [FREQ_W-1:0]    best_diff;
  logic [FREQ_W-1:0]    diff;

  logic [FREQ_W-1:0]    mul_a;
  logic [WEIGHT_W-1:0]  mul_b;
  logic [PROD_W-1:0]    prod;
  logic [ACC_W-1:0]     acc;
  logic [SUM_W-1:0]     sum_q;
  logic [WSTORE_W-1:0]  sum_sat;

  logic [SUM_W-1:0]     rem;
  logic [FREQ_W-1:0]    quot;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [SUM_W:0]       trial;
  logic [SUM_W:0]       trial_sub;
  logic                 trial_ge;

  ncl_result_t          result_q;

  assign thr_clamp = (thr > FIX_ONE) ? FIX_ONE : thr;
  assign scan_more = scan_idx < count;
  assign diff      = (freq_q >= cent_rd) ? (freq_q - cent_rd) : (cent_rd - freq_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      thr   <= '0;
      count <= '0;
    end else begin
      if (cfg_valid) begin
        thr <= cfg_threshold;
      end
      if (cmd.load && evt_start) begin
        count <= '0;
      end else if (cmd.open_new) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      freq_q   <= evt_frequency;
      weight_q <= (evt_weight == '0) ? WEIGHT_W'(1) : evt_weight;
    end
  end

  // scan: one read issued per cycle, compared in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      found    <= 1'b0;
      scan_idx <= '0;
    end else if (cmd.load) begin
      rd_valid <= 1'b0;
      found    <= 1'b0;
      scan_idx <= '0;
    end else if (cmd.scan) begin
      rd_valid <= scan_more;
      if (scan_more) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (rd_valid && (!found || diff < best_diff)) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_idx <= scan_idx[IDX_W-1:0];
      if (rd_valid && (!found || diff < best_diff)) begin
        best_idx  <= rd_idx;
        best_diff <= diff;
      end
    end
  end

  assign mem_re  = (cmd.scan && scan_more) || cmd.read_best;
  assign rd_addr = cmd.read_best ? best_idx : scan_idx[IDX_W-1:0];
  assign mem_we  = cmd.write_join || (cmd.open_new);
  assign wr_addr = cmd.write_join ? best_idx : count[IDX_W-1:0];
  assign wr_cent = cmd.write_join ? quot : freq_q;
  assign wr_wgt  = cmd.write_join ? sum_sat : WSTORE_W'(weight_q);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cent_mem[wr_addr] <= wr_cent;
      wgt_mem[wr_addr]  <= wr_wgt;
    end
    if (mem_re) begin
      cent_rd <= cent_mem[rd_addr];
      wgt_rd  <= wgt_mem[rd_addr];
    end
  end

  // numerator: centroid * weight in two partial products, then freq * weight
  always_comb begin
    mul_a = cmd.mul_ev ? freq_q : cent_rd;
    if (cmd.mul_lo) begin
      mul_b = wgt_rd[WEIGHT_W-1:0];
    end else if (cmd.mul_hi) begin
      mul_b = WEIGHT_W'(wgt_rd[WSTORE_W-1:WEIGHT_W]);
    end else begin
      mul_b = weight_q;
    end
    prod = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      acc <= ACC_W'(prod);
    end else if (cmd.mul_hi) begin
      acc <= acc + (ACC_W'(prod) << WEIGHT_W);
    end else if (cmd.mul_ev) begin
      acc   <= acc + ACC_W'(prod);
      sum_q <= SUM_W'(wgt_rd) + SUM_W'(weight_q);
    end
  end

  assign sum_sat = sum_q[SUM_W-1] ? {WSTORE_W{1'b1}} : sum_q[WSTORE_W-1:0];

  // restoring divide, one quotient bit a cycle
  assign trial     = {rem, quot[FREQ_W-1]};
  assign trial_ge  = trial >= {1'b0, sum_q};
  assign trial_sub = trial - {1'b0, sum_q};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem     <= acc[ACC_W-1:FREQ_W];
      quot    <= acc[FREQ_W-1:0];
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= trial_ge ? trial_sub[SUM_W-1:0] : trial[SUM_W-1:0];
      quot    <= {quot[FREQ_W-2:0], trial_ge};
      div_cnt <= div_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_join) begin
      result_q.cluster_index    <= OUT_IDX_W'(best_idx);
      result_q.opened_new       <= 1'b0;
      result_q.cluster_centroid <= quot;
      result_q.dropped          <= 1'b0;
    end else if (cmd.open_new) begin
      result_q.cluster_index    <= OUT_IDX_W'(count[IDX_W-1:0]);
      result_q.opened_new       <= 1'b1;
      result_q.cluster_centroid <= freq_q;
      result_q.dropped          <= 1'b0;
    end else if (cmd.drop) begin
      result_q.cluster_index    <= '0;
      result_q.opened_new       <= 1'b0;
      result_q.cluster_centroid <= '0;
      result_q.dropped          <= 1'b1;
    end
    if (cmd.emit) begin
      res_data <= result_q;
    end
  end

  assign stat.scan_done = !scan_more && !rd_valid;
  assign stat.match     = found && (best_diff <= thr_clamp);
  assign stat.full      = count == CNT_W'(MAX_CLUSTERS);
  assign stat.div_done  = div_cnt == DIV_CNT_W'(FREQ_W);

endmodule

@@ design/ncl_controller.sv @@
// ----------------------------------------------------------------------------
// ncl_controller
// Sequencer for scan, decision, weighted-mean update and result hand-off.
// ----------------------------------------------------------------------------
module ncl_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                evt_valid,
  output logic                evt_ready,
  output logic                res_valid,
  input  logic                res_ready,
  output ncl_pkg::ncl_cmd_t   cmd,
  input  ncl_pkg::ncl_stat_t  stat
);
  import ncl_pkg::*;

  ncl_state_t state;
  ncl_state_t state_next;
  logic       res_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    evt_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        evt_ready = 1'b1;
        if (evt_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_DECIDE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_DECIDE: begin
        if (stat.match) begin
          state_next = S_READ;
        end else if (!stat.full) begin
          cmd.open_new = 1'b1;
          state_next   = S_FINISH;
        end else begin
          cmd.drop   = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_READ: begin
        cmd.read_best = 1'b1;
        state_next    = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_MUL_EV;
      end
      S_MUL_EV: begin
        cmd.mul_ev = 1'b1;
        state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_JOIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_JOIN: begin
        cmd.write_join = 1'b1;
        state_next     = S_FINISH;
      end
      S_FINISH: begin
        if (!res_valid || res_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      res_valid_next = 1'b1;
    end else if (res_ready) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

endmodule

@@ design/nearest_centroid_leader_clustering_top.sv @@
// ----------------------------------------------------------------------------
// nearest_centroid_leader_clustering_top
// One-pass leader clustering of event frequencies with weighted centroids.
//
//   channel  dir  beat carries
//   evt      in   event_frequency, event_weight, start_new_set
//   res      out  cluster_index, opened_new, cluster_centroid, dropped
//   cfg      in   join_threshold (always ready)
//
// An event opens a cluster, joins the nearest one or is dropped. The scan
// reads the live clusters (at most 64) one centroid a cycle from the
// store's single read port, and the divide retires one quotient bit a
// cycle. One event is in work at a time; the next is taken while the
// result waits in the output register. Reset empties the table at once;
// the stores hold nothing meaningful until written. A stalled result holds
// the block in its final step.
// ----------------------------------------------------------------------------
module nearest_centroid_leader_clustering_top (
  input logic     clk,
  input logic     rst,
  ncl_evt_if.sink evt,
  ncl_res_if.source res,
  ncl_cfg_if.sink cfg
);
  import ncl_pkg::*;

  ncl_cmd_t    cmd;
  ncl_stat_t   stat;
  ncl_result_t res_data;

  assign cfg.ready = 1'b1;

  ncl_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt.valid),
    .evt_ready (evt.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  ncl_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .evt_frequency (evt.event_frequency),
    .evt_weight    (evt.event_weight),
    .evt_start     (evt.start_new_set),
    .cfg_valid     (cfg.valid),
    .cfg_threshold (cfg.join_threshold),
    .res_data      (res_data)
  );

  assign res.cluster_index    = res_data.cluster_index;
  assign res.opened_new       = res_data.opened_new;
  assign res.cluster_centroid = res_data.cluster_centroid;
  assign res.dropped          = res_data.dropped;

endmodule

@@ design/ncl_checker.sv @@
// ----------------------------------------------------------------------------
// ncl_checker
// Port-level checks on the leader clustering block, bound to the top level.
// ----------------------------------------------------------------------------
module ncl_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          evt_valid,
  input logic                          evt_ready,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [ncl_pkg::OUT_IDX_W-1:0] res_index,
  input logic                          res_opened,
  input logic [ncl_pkg::FREQ_W-1:0]    res_centroid,
  input logic                          res_dropped
);
  import ncl_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat withdrawn while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable({res_index, res_opened, res_centroid, res_dropped}))
    else $error("result payload changed while stalled");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_dropped |-> res_index == '0 && !res_opened && res_centroid == '0)
    else $error("dropped result carries cluster fields");

  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_ready |=> !evt_ready)
    else $error("second event taken while one is in work");

  a_no_early_res: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_ready && !res_valid |=> !res_valid)
    else $error("result appeared in the cycle after an event");

endmodule

bind nearest_centroid_leader_clustering_top ncl_checker u_ncl_checker (
  .clk          (clk),
  .rst          (rst),
  .evt_valid    (evt.valid),
  .evt_ready    (evt.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_index    (res.cluster_index),
  .res_opened   (res.opened_new),
  .res_centroid (res.cluster_centroid),
  .res_dropped  (res.dropped)
);

@@ sim/tb_nearest_centroid_leader_clustering_top.sv @@
// ----------------------------------------------------------------------------
// tb_nearest_centroid_leader_clustering_top
// Self-checking bench for the leader clustering block. A directed table walks
// the table extremes, ties, threshold clamping, zero weight, a full table and
// drops. Randomised event sets follow, most of them grouped around a few
// centres, under several threshold settings. Every result beat is compared
// field by field with a typed expectation or an in-bench cluster table model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_nearest_centroid_leader_clustering_top;
  import ncl_pkg::*;

  localparam int RANDOM_ITEMS = 470;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 100;
  localparam int SWEEP_STEP   = 1024;
  localparam logic [FREQ_W-1:0] FREQ_ONE = 17'h10000;

  typedef enum {ROW_CFG, ROW_EVENT, ROW_SWEEP} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [FREQ_W-1:0]  freq;
    logic [WEIGHT_W-1:0] weight;
    logic               start;
    int                 reps;
    bit                 typed;
    int                 want_idx;
    bit                 want_new;
    int                 want_cent;
    bit                 want_drop;
  } plan_row_t;

  localparam int PLAN_LEN = 22;

  logic clk = 1'b0;
  logic rst;

  ncl_evt_if evt ();
  ncl_res_if res ();
  ncl_cfg_if cfg ();

  nearest_centroid_leader_clustering_top dut (
    .clk (clk),
    .rst (rst),
    .evt (evt),
    .res (res),
    .cfg (cfg)
  );

  logic [FREQ_W-1:0]   centroid_of [MAX_CLUSTERS];
  logic [WSTORE_W-1:0] weight_of   [MAX_CLUSTERS];
  int                  live_clusters;
  logic [FREQ_W-1:0]   threshold_q;

  ncl_result_t pending_results [$];
  int          fault_count;
  int          cycle_count;
  bit          steady;

  plan_row_t plan [PLAN_LEN];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic ncl_result_t cluster_event(input logic [FREQ_W-1:0] freq,
                                                input logic [WEIGHT_W-1:0] wt,
                                                input logic start);
    logic [FREQ_W-1:0]   thr;
    logic [FREQ_W-1:0]   diff;
    logic [FREQ_W-1:0]   best_diff;
    logic [WEIGHT_W-1:0] wt_eff;
    logic [SUM_W-1:0]    total;
    logic [81:0]         num;
    logic [81:0]         quo;
    int                  best;
    int                  k;
    bit                  found;
    ncl_result_t         r;
    thr = (threshold_q > FREQ_ONE) ? FREQ_ONE : threshold_q;
    if (start) live_clusters = 0;
    wt_eff = (wt == '0) ? 32'd1 : wt;
    found = 1'b0;
    best = 0;
    best_diff = '0;
    for (k = 0; k < live_clusters; k++) begin
      diff = (freq >= centroid_of[k]) ? freq - centroid_of[k] : centroid_of[k] - freq;
      if (!found || diff < best_diff) begin
        best_diff = diff;
        best = k;
        found = 1'b1;
      end
    end
    r = '0;
    if (found && best_diff <= thr) begin
      total = SUM_W'(weight_of[best]) + SUM_W'(wt_eff);
      num = 82'(centroid_of[best]) * 82'(weight_of[best]) + 82'(freq) * 82'(wt_eff);
      quo = num / 82'(total);
      centroid_of[best] = quo[FREQ_W-1:0];
      weight_of[best] = total[SUM_W-1] ? {WSTORE_W{1'b1}} : total[WSTORE_W-1:0];
      r.cluster_index = OUT_IDX_W'(best);
      r.cluster_centroid = centroid_of[best];
    end else if (live_clusters < MAX_CLUSTERS) begin
      centroid_of[live_clusters] = freq;
      weight_of[live_clusters] = WSTORE_W'(wt_eff);
      r.cluster_index = OUT_IDX_W'(live_clusters);
      r.opened_new = 1'b1;
      r.cluster_centroid = freq;
      live_clusters++;
    end else begin
      r.dropped = 1'b1;
    end
    return r;
  endfunction

  task automatic queue_result(input ncl_result_t r);
    pending_results = {pending_results, r};
  endtask

  task automatic offer_event(input logic [FREQ_W-1:0] f, input logic [WEIGHT_W-1:0] w,
                             input logic s, output ncl_result_t predicted);
    while (!steady && $urandom_range(0, 99) < 32) begin
      evt.valid <= 1'b0;
      @(posedge clk);
    end
    evt.valid <= 1'b1;
    evt.event_frequency <= f;
    evt.event_weight <= w;
    evt.start_new_set <= s;
    @(posedge clk);
    while (!evt.ready) @(posedge clk);
    predicted = cluster_event(f, w, s);
  endtask

  task automatic set_threshold(input logic [FREQ_W-1:0] value);
    evt.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.join_threshold <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    threshold_q = value;
  endtask

  always @(posedge clk) begin
    res.ready <= steady || ($urandom_range(0, 99) >= 32);
  end

  always @(posedge clk) begin
    ncl_result_t want;
    if (!rst && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no event pending: index %0d centroid %0d",
               res.cluster_index, res.cluster_centroid);
        fault_count++;
      end else begin
        want = pending_results.pop_front();
        if (res.cluster_index !== want.cluster_index) begin
          $error("cluster_index: expected %0d, got %0d", want.cluster_index,
                 res.cluster_index);
          fault_count++;
        end
        if (res.opened_new !== want.opened_new) begin
          $error("opened_new: expected %0d, got %0d", want.opened_new, res.opened_new);
          fault_count++;
        end
        if (res.cluster_centroid !== want.cluster_centroid) begin
          $error("cluster_centroid: expected %0d, got %0d", want.cluster_centroid,
                 res.cluster_centroid);
          fault_count++;
        end
        if (res.dropped !== want.dropped) begin
          $error("dropped: expected %0d, got %0d", want.dropped, res.dropped);
          fault_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("nearest_centroid_leader_clustering_top regression: fail");
      $finish;
    end
  end

  initial begin
    ncl_result_t got;
    ncl_result_t typed_res;
    int          i;
    int          j;
    int          random_sent;
    int          next_phase_at;
    int          phase;
    int          set_len;
    int          n_centres;
    int          centre_at [8];
    int          spread;
    int          thr_eff;
    int          freq_i;
    logic [FREQ_W-1:0]   thr_pick;
    logic [WEIGHT_W-1:0] wt;
    logic                st;

    rst <= 1'b1;
    evt.valid <= 1'b0;
    evt.event_frequency <= '0;
    evt.event_weight <= '0;
    evt.start_new_set <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.join_threshold <= '0;
    fault_count = 0;
    steady = 1'b0;
    live_clusters = 0;
    threshold_q = '0;
    for (i = 0; i < MAX_CLUSTERS; i++) begin
      centroid_of[i] = '0;
      weight_of[i] = '0;
    end

    plan = '{
      '{ROW_EVENT, 17'h00000, 32'd1,          1'b0, 1,  1'b1, 0, 1'b1, 0,       1'b0},
      '{ROW_EVENT, 17'h10000, 32'hFFFF_FFFF,  1'b0, 1,  1'b1, 1, 1'b1, 'h10000, 1'b0},
      '{ROW_EVENT, 17'h00000, 32'd0,          1'b0, 1,  1'b1, 0, 1'b0, 0,       1'b0},
      '{ROW_EVENT, 17'h1FFFF, 32'd7,          1'b0, 1,  1'b1, 2, 1'b1, 'h1FFFF, 1'b0},
      '{ROW_CFG,   17'h1FFFF, 32'd0,          1'b0, 1,  1'b0, 0, 1'b0, 0,       1'b0},
      '{ROW_EVENT, 17'h08000, 32'd1,          1'b0, 1,  1'b0, 0, 1'b0, 0,       1'b0},
      '{ROW_EVENT, 17'h1FFFF, 32'hFFFF_FFFF,  1'b0, 1,  1'b0, 0, 1'b0, 0,       1'b0},
      '{ROW_EVENT, 17'h00000, 32'd3,          1'b1, 1,  1'b1, 0, 1'b1, 0,       1'b0},
      '{ROW_EVENT, 17'h1FFFF, 32'd3,          1'b0, 1,  1'b1, 1, 1'b1, 'h1FFFF, 1'b0},
      '{ROW_EVENT, 17'h10000, 32'd1,          1'b0, 1,  1'b0, 0, 1'b0, 0,       1'b0},
      '{ROW_CFG,   17'h10000, 32'd0,          1'b0, 1,  1'b0, 0, 1'b0, 0,       1'b0},
      '{ROW_EVENT, 17'h10000, 32'hFFFF_FFFF,  1'b1, 1,  1'b1, 0, 1'b1, 'h10000, 1'b0},
      '{ROW_EVENT, 17'h00000, 32'hFFFF_FFFF,  1'b0, 1,  1'b1, 0, 1'b0, 'h08000, 1'b0},
      '{ROW_CFG,   17'h00000, 32'd0,          1'b0, 1,  1'b0, 0, 1'b0, 0,       1'b0},
      '{ROW_EVENT, 17'd100,   32'd1,          1'b1, 1,  1'b1, 0, 1'b1, 100,     1'b0},
      '{ROW_SWEEP, 17'd1024,  32'd1,          1'b0, 63, 1'b0, 0, 1'b0, 0,       1'b0},
      '{ROW_EVENT, 17'h1FFFF, 32'd1,          1'b0, 1,  1'b1, 0, 1'b0, 0,       1'b1},
      '{ROW_EVENT, 17'd1024,  32'd9,          1'b0, 1,  1'b1, 1, 1'b0, 1024,    1'b0},
      '{ROW_EVENT, 17'h00000, 32'd1,          1'b0, 1,  1'b1, 0, 1'b0, 0,       1'b1},
      '{ROW_CFG,   17'd100,   32'd0,          1'b0, 1,  1'b0, 0, 1'b0, 0,       1'b0},
      '{ROW_EVENT, 17'h00000, 32'd1,          1'b0, 1,  1'b1, 0, 1'b0, 50,      1'b0},
      '{ROW_EVENT, 17'h10000, 32'hFFFF_FFFF,  1'b1, 1,  1'b1, 0, 1'b1, 'h10000, 1'b0}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < PLAN_LEN; i++) begin
      case (plan[i].kind)
        ROW_CFG: begin
          set_threshold(plan[i].freq);
        end
        ROW_EVENT: begin
          offer_event(plan[i].freq, plan[i].weight, plan[i].start, got);
          if (plan[i].typed) begin
            typed_res.cluster_index = OUT_IDX_W'(plan[i].want_idx);
            typed_res.opened_new = plan[i].want_new;
            typed_res.cluster_centroid = FREQ_W'(plan[i].want_cent);
            typed_res.dropped = plan[i].want_drop;
            queue_result(typed_res);
          end else begin
            queue_result(got);
          end
        end
        default: begin
          for (j = 0; j < plan[i].reps; j++) begin
            offer_event(plan[i].freq + FREQ_W'(j * SWEEP_STEP), plan[i].weight,
                        plan[i].start, got);
            queue_result(got);
          end
        end
      endcase
    end

    random_sent = 0;
    next_phase_at = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent >= next_phase_at) begin
        case (phase % 8)
          0: thr_pick = FREQ_W'($urandom_range(0, 2000));
          1: thr_pick = FREQ_ONE;
          2: thr_pick = '0;
          3: thr_pick = 17'h1FFFF;
          4: thr_pick = FREQ_W'($urandom);
          5: thr_pick = 17'd1;
          6: thr_pick = FREQ_W'($urandom_range(0, 8000));
          default: thr_pick = 17'h0FFFF;
        endcase
        set_threshold(thr_pick);
        phase++;
        next_phase_at += 70;
      end
      thr_eff = (threshold_q > FREQ_ONE) ? int'(FREQ_ONE) : int'(threshold_q);
      n_centres = $urandom_range(1, 8);
      for (j = 0; j < 8; j++) begin
        centre_at[j] = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65536)
                                                   : $urandom_range(0, 131071);
      end
      case ($urandom_range(0, 3))
        0: spread = 0;
        1: spread = thr_eff / 2;
        2: spread = thr_eff + 2;
        default: spread = 4096;
      endcase
      set_len = $urandom_range(1, 90);
      for (j = 0; j < set_len && random_sent < RANDOM_ITEMS; j++) begin
        case ($urandom_range(0, 9))
          0, 1: freq_i = $urandom_range(0, 131071);
          2, 3: freq_i = $urandom_range(0, 65536);
          default: begin
            freq_i = centre_at[$urandom_range(0, n_centres - 1)]
                     + int'($urandom_range(0, 2 * spread)) - spread;
            if (freq_i < 0) freq_i = 0;
            if (freq_i > 131071) freq_i = 131071;
          end
        endcase
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4: wt = 32'd1;
          5, 6: wt = '0;
          7, 8: wt = 32'hFFFF_FFFF;
          9, 10, 11, 12, 13, 14: wt = WEIGHT_W'($urandom_range(1, 1000));
          default: wt = $urandom;
        endcase
        if (j == 0) st = ($urandom_range(0, 9) != 0);
        else st = ($urandom_range(0, 99) < 3);
        steady = (random_sent >= 200 && random_sent < 320);
        offer_event(FREQ_W'(freq_i), wt, st, got);
        queue_result(got);
        random_sent++;
      end
    end

    evt.valid <= 1'b0;
    steady = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("nearest_centroid_leader_clustering_top regression: pass");
    end else begin
      $display("nearest_centroid_leader_clustering_top regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/ncl_pkg.sv
design/ncl_if.sv
design/ncl_datapath.sv
design/ncl_controller.sv
design/nearest_centroid_leader_clustering_top.sv
design/ncl_checker.sv
sim/tb_nearest_centroid_leader_clustering_top.sv
